>>> src/bgnc_pkg.sv
`timescale 1ns / 1ps

package bgnc_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WCFG_W      = 6;
    localparam int HCFG_W      = 16;
    localparam int ROW_W       = 16;
    localparam int CNT_W       = 4;
    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int POS_W       = $clog2(MAX_WIDTH + 2);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [WCFG_W-1:0] GRID_WIDTH_RST  = 6'd32;
    localparam logic [HCFG_W-1:0] GRID_HEIGHT_RST = 16'd1;

    // Window bit k is row k/3 (0 = two rows up) and column k%3 (0 = two cells left).
    localparam logic [8:0] WIN_TOP_ROW = 9'b000_000_111;
    localparam logic [8:0] WIN_COL0    = 9'b001_001_001;
    localparam logic [8:0] WIN_COL1    = 9'b010_010_010;
    localparam logic [8:0] WIN_SHIFT   = 9'b011_011_011;

    // Result positions inside one job: two window results, then the row flush.
    localparam logic [POS_W-1:0] POS_PRE0  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PRE1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FLUSH = POS_W'(2);

    typedef struct packed {
        logic [1:0]           pre_valid;
        logic [CNT_W-1:0]     pre_count0;
        logic [CNT_W-1:0]     pre_count1;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 flush;
        logic                 has_older;
        logic [COL_W-1:0]     w_m1;
        logic [MAX_WIDTH-1:0] recent_bits;
        logic [MAX_WIDTH-1:0] older_bits;
    } job_t;

    function automatic logic [CNT_W-1:0] ones9(input logic [8:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < 9; i++)
        begin
            s = s + CNT_W'(v[i]);
        end
        return s;
    endfunction

endpackage

>>> src/binary_grid_3x3_neighbor_count.sv
`timescale 1ns / 1ps

// Streaming 3x3 box sum over a binary grid sent in raster order, one cell per request.
// Each result carries the number of set cells in the window around one cell, with
// positions outside the grid left out, plus its row and column. A cell's result
// leaves once the cell below and to its right has arrived, and the frame's last cell
// flushes the whole final row, the final result marked end_of_frame. The front stage
// takes one cell per clock while in_stall is low and turns it into a job; the back
// stage emits one result per clock from its job register while out_stall is low. The
// last cell of a row below the first yields a second result, and the frame's last
// cell also yields the flush of the final row; meanwhile the two-entry job queue
// fills and in_stall rises. With the back stage idle, a result passes through the
// job queue, the job register and the output registers. Writing either register
// (index 0 width, 1 height) restarts the frame at row 0, column 0.
module binary_grid_3x3_neighbor_count (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bgnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgnc_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cell_req,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bgnc_pkg::CNT_W-1:0]     count,
    output logic [bgnc_pkg::ROW_W-1:0]     row_index,
    output logic [bgnc_pkg::COL_W-1:0]     col_index,
    output logic                           last_of_run,
    output logic                           end_of_frame
);

    bgnc_pkg::job_t push_job, head_job;
    logic           q_push_valid, q_push_ready, q_pop_valid, q_pop;

    bgnc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_req  (cell_req),
        .job_valid (q_push_valid),
        .job_ready (q_push_ready),
        .job       (push_job)
    );

    bgnc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (push_job),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_data   (head_job)
    );

    bgnc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_pop_valid),
        .job_head     (head_job),
        .job_pop      (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .count        (count),
        .row_index    (row_index),
        .col_index    (col_index),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

    // The front never pushes a job into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid |-> q_push_ready)
        else $error("job pushed into a full queue");

    // The back only pops a job that is present.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_pop_valid)
        else $error("job popped from an empty queue");

    // The frame's final result always closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> last_of_run)
        else $error("end of frame without end of run");

    // A 3x3 window holds at most nine set cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= 4'd9))
        else $error("window count out of range");

endmodule

>>> src/bgnc_front.sv
`timescale 1ns / 1ps

module bgnc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bgnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgnc_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cell_req,
    output logic                           job_valid,
    input  logic                           job_ready,
    output bgnc_pkg::job_t                 job
);

    logic [bgnc_pkg::WCFG_W-1:0]    width_reg;
    logic [bgnc_pkg::HCFG_W-1:0]    height_reg;
    logic [bgnc_pkg::COL_W-1:0]     col_reg, col_next;
    logic [bgnc_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [8:0]                     win_reg, win_next;
    logic [bgnc_pkg::MAX_WIDTH-1:0] older_reg, older_next;
    logic [bgnc_pkg::MAX_WIDTH-1:0] recent_reg, recent_next;

    logic [bgnc_pkg::WCFG_W-1:0] w_dec;
    logic [bgnc_pkg::COL_W-1:0]  w_m1;
    logic [bgnc_pkg::HCFG_W-1:0] h_m1;
    logic                        o_bit, n_bit;
    logic [8:0]                  row_mask, mask0, mask1;
    logic                        end_col, end_row, accept, job_any;

    always_comb
    begin
        w_dec = width_reg - bgnc_pkg::WCFG_W'(1);
        if (width_reg == '0)
        begin
            w_m1 = '0;
        end
        else if (width_reg > bgnc_pkg::WCFG_W'(bgnc_pkg::MAX_WIDTH))
        begin
            w_m1 = bgnc_pkg::COL_W'(bgnc_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = w_dec[bgnc_pkg::COL_W-1:0];
        end
        h_m1 = (height_reg == '0) ? '0 : height_reg - bgnc_pkg::HCFG_W'(1);

        o_bit    = older_reg[col_reg];
        n_bit    = recent_reg[col_reg];
        win_next = ((win_reg >> 1) & bgnc_pkg::WIN_SHIFT)
                 | {cell_req, 2'b00, n_bit, 2'b00, o_bit, 2'b00};

        // Rows above the grid and columns left of it are masked out of the sums.
        row_mask = (row_reg > bgnc_pkg::ROW_W'(1)) ? 9'h1FF : ~bgnc_pkg::WIN_TOP_ROW;
        mask0    = row_mask & ((col_reg > bgnc_pkg::COL_W'(1)) ? 9'h1FF : ~bgnc_pkg::WIN_COL0);
        mask1    = row_mask & ((col_reg != '0) ? ~bgnc_pkg::WIN_COL0
                                              : ~(bgnc_pkg::WIN_COL0 | bgnc_pkg::WIN_COL1));

        end_col = (col_reg == w_m1);
        end_row = (row_reg == h_m1);

        older_next           = older_reg;
        older_next[col_reg]  = n_bit;
        recent_next          = recent_reg;
        recent_next[col_reg] = cell_req;

        job.pre_valid[0] = (row_reg != '0) && (col_reg != '0);
        job.pre_valid[1] = (row_reg != '0) && end_col;
        job.pre_count0   = bgnc_pkg::ones9(win_next & mask0);
        job.pre_count1   = bgnc_pkg::ones9(win_next & mask1);
        job.row          = row_reg;
        job.col          = col_reg;
        job.flush        = end_col && end_row;
        job.has_older    = (row_reg != '0);
        job.w_m1         = w_m1;
        job.recent_bits  = recent_next;
        job.older_bits   = older_next;

        job_any   = (job.pre_valid != 2'b00) || job.flush;
        in_stall  = !job_ready;
        accept    = in_valid && !in_stall;
        job_valid = accept && job_any;

        col_next = col_reg;
        row_next = row_reg;
        if (job.flush)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (end_col)
        begin
            col_next = '0;
            row_next = row_reg + bgnc_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + bgnc_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bgnc_pkg::GRID_WIDTH_RST;
            height_reg <= bgnc_pkg::GRID_HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            win_reg    <= '0;
        end
        else if (cfg_we)
        begin
            // Any register write abandons the frame in progress.
            if (cfg_index == bgnc_pkg::CFG_GRID_WIDTH)
            begin
                width_reg <= cfg_data[bgnc_pkg::WCFG_W-1:0];
            end
            else
            begin
                height_reg <= cfg_data[bgnc_pkg::HCFG_W-1:0];
            end
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= job.flush ? 9'h000 : win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_we)
        begin
            older_reg  <= older_next;
            recent_reg <= recent_next;
        end
    end

endmodule

>>> src/bgnc_queue.sv
`timescale 1ns / 1ps

module bgnc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bgnc_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop,
    output bgnc_pkg::job_t pop_data
);

    bgnc_pkg::job_t                mem [bgnc_pkg::QUEUE_DEPTH];
    logic [bgnc_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [bgnc_pkg::QPTR_W:0]     fill_reg, fill_next;
    logic                          do_push, do_pop;

    always_comb
    begin
        push_ready = (fill_reg != (bgnc_pkg::QPTR_W + 1)'(bgnc_pkg::QUEUE_DEPTH));
        pop_valid  = (fill_reg != '0);
        pop_data   = mem[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop && pop_valid;
        fill_next  = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (bgnc_pkg::QPTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (bgnc_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bgnc_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bgnc_pkg::QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/bgnc_back.sv
`timescale 1ns / 1ps

module bgnc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  bgnc_pkg::job_t             job_head,
    output logic                       job_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bgnc_pkg::CNT_W-1:0] count,
    output logic [bgnc_pkg::ROW_W-1:0] row_index,
    output logic [bgnc_pkg::COL_W-1:0] col_index,
    output logic                       last_of_run,
    output logic                       end_of_frame
);

    bgnc_pkg::job_t               job_reg, job_next;
    logic                         busy_reg, busy_next;
    logic [bgnc_pkg::POS_W-1:0]   pos_reg, pos_next, pos_step, pos_start, pos_off;
    logic                         out_valid_reg, out_valid_next;
    logic [bgnc_pkg::CNT_W-1:0]   count_reg, res_count;
    logic [bgnc_pkg::ROW_W-1:0]   row_reg, res_row;
    logic [bgnc_pkg::COL_W-1:0]   col_reg, res_col;
    logic                         last_reg, eof_reg, res_last, res_eof;
    logic [bgnc_pkg::COL_W-1:0]   x, xl, xr;
    logic                         left_ok, right_ok;
    logic [8:0]                   flush_bits;
    logic                         adv, fire;

    always_comb
    begin
        // Flush sum for column x of the final row over the snapshot of both rows.
        pos_off  = pos_reg - bgnc_pkg::POS_FLUSH;
        x        = pos_off[bgnc_pkg::COL_W-1:0];
        xl       = x - bgnc_pkg::COL_W'(1);
        xr       = x + bgnc_pkg::COL_W'(1);
        left_ok  = (x != '0);
        right_ok = (x != job_reg.w_m1);
        flush_bits = {3'b000,
                      job_reg.recent_bits[x],
                      left_ok  && job_reg.recent_bits[xl],
                      right_ok && job_reg.recent_bits[xr],
                      job_reg.has_older && job_reg.older_bits[x],
                      job_reg.has_older && left_ok  && job_reg.older_bits[xl],
                      job_reg.has_older && right_ok && job_reg.older_bits[xr]};

        case (pos_reg)
            bgnc_pkg::POS_PRE0:
            begin
                res_count = job_reg.pre_count0;
                res_row   = job_reg.row - bgnc_pkg::ROW_W'(1);
                res_col   = job_reg.col - bgnc_pkg::COL_W'(1);
                res_eof   = 1'b0;
                res_last  = !job_reg.pre_valid[1] && !job_reg.flush;
                pos_step  = job_reg.pre_valid[1] ? bgnc_pkg::POS_PRE1 : bgnc_pkg::POS_FLUSH;
            end
            bgnc_pkg::POS_PRE1:
            begin
                res_count = job_reg.pre_count1;
                res_row   = job_reg.row - bgnc_pkg::ROW_W'(1);
                res_col   = job_reg.col;
                res_eof   = 1'b0;
                res_last  = !job_reg.flush;
                pos_step  = bgnc_pkg::POS_FLUSH;
            end
            default:
            begin
                res_count = bgnc_pkg::ones9(flush_bits);
                res_row   = job_reg.row;
                res_col   = x;
                res_eof   = !right_ok;
                res_last  = !right_ok;
                pos_step  = pos_reg + bgnc_pkg::POS_W'(1);
            end
        endcase

        if (job_head.pre_valid[0])
        begin
            pos_start = bgnc_pkg::POS_PRE0;
        end
        else if (job_head.pre_valid[1])
        begin
            pos_start = bgnc_pkg::POS_PRE1;
        end
        else
        begin
            pos_start = bgnc_pkg::POS_FLUSH;
        end

        adv     = !out_valid_reg || !out_stall;
        fire    = busy_reg && adv;
        job_pop = job_valid && (!busy_reg || (fire && res_last));

        job_next  = job_reg;
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (job_pop)
        begin
            job_next  = job_head;
            busy_next = 1'b1;
            pos_next  = pos_start;
        end
        else if (fire && res_last)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            pos_next = pos_step;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= bgnc_pkg::POS_PRE0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (fire)
        begin
            count_reg <= res_count;
            row_reg   <= res_row;
            col_reg   <= res_col;
            last_reg  <= res_last;
            eof_reg   <= res_eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign count        = count_reg;
    assign row_index    = row_reg;
    assign col_index    = col_reg;
    assign last_of_run  = last_reg;
    assign end_of_frame = eof_reg;

endmodule
